// ===== rtl/integer_builtin_function_unit_top_assert.svh =====
// Assertion macros for the integer builtin function unit.
`ifndef INTEGER_BUILTIN_FUNCTION_UNIT_TOP_ASSERT_SVH
`define INTEGER_BUILTIN_FUNCTION_UNIT_TOP_ASSERT_SVH

`define IBFU_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

`define IBFU_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ibfu_pkg.sv =====
package ibfu_pkg;

    localparam logic [63:0] SEED_RESET  = 64'h1234567890abcdef;
    localparam logic [63:0] SEED_OFFSET = 64'd6364136223846793;
    localparam logic [63:0] WORD1_SEED  = 64'd6364136223846793005;
    localparam logic [63:0] RANDOM_MASK = 64'h000000007fffffff;
    localparam logic [5:0]  CURVE_CAP   = 6'd15;

    localparam logic [2:0] OP_ABS    = 3'd0;
    localparam logic [2:0] OP_MIN    = 3'd1;
    localparam logic [2:0] OP_MAX    = 3'd2;
    localparam logic [2:0] OP_CLAMP  = 3'd3;
    localparam logic [2:0] OP_MAP    = 3'd4;
    localparam logic [2:0] OP_LERP   = 3'd5;
    localparam logic [2:0] OP_SMOOTH = 3'd6;
    localparam logic [2:0] OP_RANDOM = 3'd7;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    localparam logic [2:0] KIND_I32 = 3'd6;
    localparam logic [2:0] KIND_I64 = 3'd7;

    typedef enum logic [4:0] {
        S_ADV0, S_ADV1, S_IDLE, S_DECODE, S_MAP_SORT, S_MAP_START, S_MUL_MAP,
        S_DIV_START, S_DIV, S_MAP_FIN, S_FIX_START, S_MUL_SQ, S_SM2, S_MUL_CUBE,
        S_SM3, S_MUL_FIX, S_FIX_FIN, S_DONE
    } ibfu_state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_RESEED, CMD_RNG_ADV, CMD_CAPTURE, CMD_DIRECT, CMD_SORT,
        CMD_MAP_START, CMD_MUL_STEP, CMD_DIV_START, CMD_DIV_STEP, CMD_MAP_FIN,
        CMD_FIX_START, CMD_SM2, CMD_SM3, CMD_FIX_FIN, CMD_OUT
    } ibfu_cmd_t;

    typedef struct packed {
        ibfu_cmd_t cmd;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       fixed_ok;
        logic       span_zero;
        logic       fix_edge;
        logic       cnt_last;
    } dp_status_t;

    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        case (wc)
            WC_8:    m = 64'h00000000000000ff;
            WC_16:   m = 64'h000000000000ffff;
            WC_32:   m = 64'h00000000ffffffff;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] calc_mask(input logic [1:0] wc);
        return (wc == WC_64) ? '1 : 64'h00000000ffffffff;
    endfunction

    function automatic logic [63:0] sext_w(input logic [63:0] x, input logic [1:0] wc);
        logic [63:0] r;
        case (wc)
            WC_8:    r = {{56{x[7]}}, x[7:0]};
            WC_16:   r = {{48{x[15]}}, x[15:0]};
            WC_32:   r = {{32{x[31]}}, x[31:0]};
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] ext_arg(input logic [63:0] x, input logic [2:0] kind);
        return kind[2] ? sext_w(x, kind[1:0]) : (x & width_mask(kind[1:0]));
    endfunction

    function automatic logic is_less(input logic [63:0] a, input logic [63:0] b,
                                     input logic sgn);
        return sgn ? ($signed(a) < $signed(b)) : (a < b);
    endfunction

    function automatic logic [63:0] asr_w(input logic [63:0] x, input logic [5:0] n,
                                          input logic [1:0] wc);
        logic [63:0] v;
        v = sext_w(x, wc);
        return 64'($signed(v) >>> n) & width_mask(wc);
    endfunction

endpackage

// ===== rtl/integer_builtin_function_unit_top.sv =====
// Integer builtin unit: one item in, one result item out, one item at a time.
// Abs, min, max, clamp, random and lerp or smoothstep on kinds other than i32
// and i64 are computed directly in the decode state and registered to the
// output in the done state. Map sorts its ranges, then runs one pass of the
// shared bit-serial 64-step multiplier and the 64-step restoring divider
// unless the input span is zero. Lerp runs one multiplier pass and smoothstep
// three, unless t lies at or beyond either end of its range. A result that is
// still waiting for m_tready holds the next one back for as long as it waits.
// After reset and after each seed write the generator is advanced twice,
// which holds off input items while it runs. The seed is written only while
// the unit is idle.
module integer_builtin_function_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value_arg, second_arg, third_arg, fourth_arg, fifth_arg, frac_shift, zero pad
    input  logic [327:0] s_tdata,
    // operation, kind
    input  logic [5:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_bits
    output logic [63:0]  m_tdata,
    // fault
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_wdata
);
    import ibfu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ibfu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ibfu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`include "integer_builtin_function_unit_top_assert.svh"

    `IBFU_ASSERT_NOW(a_no_dual_accept, s_tvalid && s_tready, !(cfg_valid && cfg_ready), "item and seed write accepted together")
    `IBFU_ASSERT_NEXT(a_busy_after_item, s_tvalid && s_tready, !s_tready && !cfg_ready, "unit not busy after accepting an item")
    `IBFU_ASSERT_NEXT(a_busy_after_seed, cfg_valid && cfg_ready, !s_tready && cmd.cmd == CMD_RNG_ADV, "generator not advanced after seed write")

endmodule

// ===== rtl/ibfu_ctrl.sv =====
module ibfu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ibfu_pkg::dp_status_t status,
    output ibfu_pkg::dp_cmd_t    cmd
);
    import ibfu_pkg::*;

    ibfu_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_ADV0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.cmd        = CMD_NONE;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cfg_ready      = 1'b0;
        case (state_reg)
            S_ADV0: begin
                cmd.cmd    = CMD_RNG_ADV;
                state_next = S_ADV1;
            end
            S_ADV1: begin
                cmd.cmd    = CMD_RNG_ADV;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cmd    = CMD_RESEED;
                    state_next = S_ADV0;
                end else if (s_tvalid) begin
                    cmd.cmd    = CMD_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (status.op == OP_MAP) begin
                    state_next = S_MAP_SORT;
                end else if ((status.op == OP_LERP || status.op == OP_SMOOTH)
                             && status.fixed_ok) begin
                    state_next = S_FIX_START;
                end else begin
                    cmd.cmd    = CMD_DIRECT;
                    state_next = S_DONE;
                end
            end
            S_MAP_SORT: begin
                cmd.cmd    = CMD_SORT;
                state_next = S_MAP_START;
            end
            S_MAP_START: begin
                cmd.cmd    = CMD_MAP_START;
                state_next = status.span_zero ? S_DONE : S_MUL_MAP;
            end
            S_MUL_MAP: begin
                cmd.cmd = CMD_MUL_STEP;
                if (status.cnt_last) state_next = S_DIV_START;
            end
            S_DIV_START: begin
                cmd.cmd    = CMD_DIV_START;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.cmd = CMD_DIV_STEP;
                if (status.cnt_last) state_next = S_MAP_FIN;
            end
            S_MAP_FIN: begin
                cmd.cmd    = CMD_MAP_FIN;
                state_next = S_DONE;
            end
            S_FIX_START: begin
                cmd.cmd = CMD_FIX_START;
                if (status.fix_edge) state_next = S_DONE;
                else if (status.op == OP_SMOOTH) state_next = S_MUL_SQ;
                else state_next = S_MUL_FIX;
            end
            S_MUL_SQ: begin
                cmd.cmd = CMD_MUL_STEP;
                if (status.cnt_last) state_next = S_SM2;
            end
            S_SM2: begin
                cmd.cmd    = CMD_SM2;
                state_next = S_MUL_CUBE;
            end
            S_MUL_CUBE: begin
                cmd.cmd = CMD_MUL_STEP;
                if (status.cnt_last) state_next = S_SM3;
            end
            S_SM3: begin
                cmd.cmd    = CMD_SM3;
                state_next = S_MUL_FIX;
            end
            S_MUL_FIX: begin
                cmd.cmd = CMD_MUL_STEP;
                if (status.cnt_last) state_next = S_FIX_FIN;
            end
            S_FIX_FIN: begin
                cmd.cmd    = CMD_FIX_FIN;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.cmd        = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/ibfu_dp.sv =====
module ibfu_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ibfu_pkg::dp_cmd_t    cmd,
    output ibfu_pkg::dp_status_t status,
    input  logic [5:0]           s_tuser,
    input  logic [327:0]         s_tdata,
    input  logic [63:0]          cfg_wdata,
    output logic [63:0]          m_tdata,
    output logic                 m_tuser
);
    import ibfu_pkg::*;

    logic [2:0]  op_reg, kind_reg;
    logic [5:0]  fs_reg, shamt_reg, cnt_reg;
    logic [63:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] mcand_reg, mplier_reg, acc_reg, rem_reg, quo_reg, span_reg;
    logic [63:0] res_reg, out_data_reg;
    logic        fault_reg, out_fault_reg;
    logic [63:0] w0_reg, w1_reg;

    logic        sgn;
    logic [1:0]  wc;
    logic [63:0] cm, span_c, vcl, max_t, aa, rng_out, rng_x, direct_res;
    logic [5:0]  shift_cap, shift_eff, cs;
    logic        edge_low, edge_high;
    logic [64:0] rem_sh;
    logic        rem_ge;

    assign sgn = kind_reg[2];
    assign wc  = kind_reg[1:0];
    assign cm  = calc_mask(wc);
    assign span_c = (c_reg - b_reg) & cm;
    assign vcl = is_less(a_reg, b_reg, sgn) ? b_reg :
                 (is_less(c_reg, a_reg, sgn) ? c_reg : a_reg);

    assign shift_cap = (wc == WC_64) ? 6'd62 : 6'd30;
    assign shift_eff = (fs_reg > shift_cap) ? shift_cap : fs_reg;
    assign cs        = (shift_eff > CURVE_CAP) ? CURVE_CAP : shift_eff;
    assign max_t     = 64'd1 << shift_eff;
    assign edge_low  = !($signed(64'd0) < $signed(c_reg));
    assign edge_high = !($signed(c_reg) < $signed(max_t));
    assign aa        = (64'd3 << shamt_reg) - (c_reg << 1);

    assign rng_out = w0_reg + w1_reg;
    assign rng_x   = w0_reg ^ (w0_reg << 23);

    assign rem_sh = {rem_reg, quo_reg[63]};
    assign rem_ge = rem_sh >= {1'b0, span_reg};

    always_comb begin
        case (op_reg)
            OP_ABS:    direct_res = (sgn && a_reg[63]) ? (64'd0 - a_reg) : a_reg;
            OP_MIN:    direct_res = is_less(b_reg, a_reg, sgn) ? b_reg : a_reg;
            OP_MAX:    direct_res = is_less(a_reg, b_reg, sgn) ? b_reg : a_reg;
            OP_CLAMP:  direct_res = is_less(a_reg, b_reg, sgn) ? b_reg :
                                    (is_less(c_reg, a_reg, sgn) ? c_reg : a_reg);
            OP_RANDOM: direct_res = rng_out & RANDOM_MASK;
            default:   direct_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w0_reg <= SEED_RESET + SEED_OFFSET;
            w1_reg <= WORD1_SEED;
        end else if (cmd.cmd == CMD_RESEED) begin
            w0_reg <= cfg_wdata + SEED_OFFSET;
            w1_reg <= WORD1_SEED;
        end else if (cmd.cmd == CMD_RNG_ADV
                     || (cmd.cmd == CMD_DIRECT && op_reg == OP_RANDOM)) begin
            w0_reg <= w1_reg;
            w1_reg <= rng_x ^ w1_reg ^ (rng_x >> 18) ^ (w1_reg >> 5);
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.cmd)
            CMD_CAPTURE: begin
                op_reg    <= s_tuser[2:0];
                kind_reg  <= s_tuser[5:3];
                a_reg     <= ext_arg(s_tdata[63:0], s_tuser[5:3]);
                b_reg     <= ext_arg(s_tdata[127:64], s_tuser[5:3]);
                c_reg     <= ext_arg(s_tdata[191:128], s_tuser[5:3]);
                d_reg     <= ext_arg(s_tdata[255:192], s_tuser[5:3]);
                e_reg     <= ext_arg(s_tdata[319:256], s_tuser[5:3]);
                fs_reg    <= s_tdata[325:320];
                fault_reg <= 1'b0;
            end
            CMD_DIRECT: res_reg <= direct_res;
            CMD_SORT: begin
                if (is_less(c_reg, b_reg, sgn)) begin
                    b_reg <= c_reg;
                    c_reg <= b_reg;
                end
                if (is_less(e_reg, d_reg, sgn)) begin
                    d_reg <= e_reg;
                    e_reg <= d_reg;
                end
            end
            CMD_MAP_START: begin
                res_reg    <= d_reg;
                fault_reg  <= (span_c == 64'd0);
                span_reg   <= span_c;
                mcand_reg  <= (vcl - b_reg) & cm;
                mplier_reg <= (e_reg - d_reg) & cm;
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            CMD_MUL_STEP: begin
                acc_reg    <= acc_reg + (mplier_reg[0] ? mcand_reg : 64'd0);
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + 6'd1;
            end
            CMD_DIV_START: begin
                quo_reg <= acc_reg & cm;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            CMD_DIV_STEP: begin
                rem_reg <= rem_ge ? 64'(rem_sh - {1'b0, span_reg}) : rem_sh[63:0];
                quo_reg <= {quo_reg[62:0], rem_ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            CMD_MAP_FIN: res_reg <= (quo_reg + d_reg) & cm;
            CMD_FIX_START: begin
                res_reg   <= edge_low ? a_reg : b_reg;
                shamt_reg <= (op_reg == OP_SMOOTH) ? cs : shift_eff;
                acc_reg   <= '0;
                cnt_reg   <= '0;
                if (op_reg == OP_SMOOTH) begin
                    mcand_reg  <= c_reg;
                    mplier_reg <= c_reg;
                end else begin
                    mcand_reg  <= b_reg - a_reg;
                    mplier_reg <= c_reg;
                end
            end
            CMD_SM2: begin
                mcand_reg  <= acc_reg;
                mplier_reg <= aa;
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            CMD_SM3: begin
                mcand_reg  <= b_reg - a_reg;
                mplier_reg <= asr_w(acc_reg, {shamt_reg[4:0], 1'b0}, WC_64)
                              & width_mask(wc);
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            CMD_FIX_FIN: begin
                res_reg <= (a_reg + asr_w(acc_reg & width_mask(wc), shamt_reg, wc))
                           & width_mask(wc);
            end
            CMD_OUT: begin
                out_data_reg  <= res_reg & width_mask(wc);
                out_fault_reg <= fault_reg;
            end
            default: ;
        endcase
    end

    assign status.op        = op_reg;
    assign status.fixed_ok  = (kind_reg == KIND_I32) || (kind_reg == KIND_I64);
    assign status.span_zero = (span_c == 64'd0);
    assign status.fix_edge  = edge_low || edge_high;
    assign status.cnt_last  = (cnt_reg == 6'd63);

    assign m_tdata = out_data_reg;
    assign m_tuser = out_fault_reg;

endmodule
